>>> rtl/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types, register offsets and codes for the DMA channel transfer engine.
// ----------------------------------------------------------------------------
package dct_pkg;

    // operation codes
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_STEP  = 3'd4;

    // register offsets
    localparam logic [7:0] REG_CTRL     = 8'd0;
    localparam logic [7:0] REG_PORT     = 8'd1;
    localparam logic [7:0] REG_ADDR_LO  = 8'd2;
    localparam logic [7:0] REG_ADDR_HI  = 8'd3;
    localparam logic [7:0] REG_ADDR_BNK = 8'd4;
    localparam logic [7:0] REG_CNT_LO   = 8'd5;
    localparam logic [7:0] REG_CNT_HI   = 8'd6;

    // control byte fields
    localparam int CTRL_DIR_BIT = 7;
    localparam int CTRL_DEC_BIT = 4;
    localparam int CTRL_FIX_BIT = 3;

    // transfer kinds
    localparam logic [1:0] KIND_COPY = 2'd0;
    localparam logic [1:0] KIND_TIME = 2'd1;
    localparam logic [1:0] KIND_FILL = 2'd2;

    localparam logic [13:0] B_BASE        = 14'h2100;
    localparam logic [7:0]  WRAM_PORT     = 8'h80;
    localparam logic [4:0]  CYC_BYTE      = 5'd8;
    localparam logic [4:0]  CYC_FILL      = 5'd4;
    localparam logic [4:0]  CYC_FIRST_ADD = 5'd8;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] reg_index;
        logic [7:0] write_data;
        logic       a_in_work_ram;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        bad_register;
        logic        bus_valid;
        logic [23:0] a_bus_address;
        logic [13:0] b_bus_address;
        logic        b_to_a;
        logic [1:0]  transfer_kind;
        logic [4:0]  master_cycles;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0]  control;
        logic [7:0]  port;
        logic [23:0] a_addr;
        logic [15:0] count;
        logic        active;
        logic [1:0]  phase;
        logic        first;
    } chan_state_t;

    // B-bus offset for the step index within a group of four
    function automatic logic [1:0] mode_offset(input logic [2:0] mode,
                                               input logic [1:0] idx);
        logic [1:0] off;
        begin
            case (mode)
                3'd1, 3'd5: off = {1'b0, idx[0]};
                3'd3, 3'd7: off = {1'b0, idx[1]};
                3'd4:       off = idx;
                default:    off = 2'd0;
            endcase
            return off;
        end
    endfunction

endpackage

>>> rtl/dct_chan_regs.sv
// ----------------------------------------------------------------------------
// dct_chan_regs
// Channel register file and run state, updated once per executed word.
// ----------------------------------------------------------------------------
module dct_chan_regs
    import dct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        update,
    input  chan_state_t state_next,
    output chan_state_t state
);

    // idle channel, all registers zero, first-step flag set
    localparam chan_state_t STATE_RESET = '{control: 8'd0, port: 8'd0, a_addr: 24'd0,
                                            count: 16'd0, active: 1'b0, phase: 2'd0,
                                            first: 1'b1};

    chan_state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (update)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

>>> rtl/dct_exec.sv
// ----------------------------------------------------------------------------
// dct_exec
// Executes one word against the channel state: result and next state.
// ----------------------------------------------------------------------------
module dct_exec
    import dct_pkg::*;
(
    input  item_t       item,
    input  chan_state_t state,
    output result_t     result,
    output chan_state_t state_next
);

    logic        b2a;
    logic        wram_port;
    logic [7:0]  b_low;
    logic [15:0] lo_step;
    logic [15:0] cnt_dec;
    logic [4:0]  cyc_base;

    always_comb
    begin
        b2a       = state.control[CTRL_DIR_BIT];
        wram_port = (state.port == WRAM_PORT) && item.a_in_work_ram;
        b_low     = state.port + {6'd0, mode_offset(state.control[2:0], state.phase)};
        lo_step   = state.control[CTRL_DEC_BIT] ? state.a_addr[15:0] - 16'd1
                                                : state.a_addr[15:0] + 16'd1;
        cnt_dec   = state.count - 16'd1;
        cyc_base  = (wram_port && b2a) ? CYC_FILL : CYC_BYTE;

        result     = '0;
        state_next = state;

        case (item.operation)
            OP_READ, OP_WRITE:
            begin
                if (item.reg_index > REG_CNT_HI)
                begin
                    result.bad_register = 1'b1;
                end
                else if (item.operation == OP_READ)
                begin
                    case (item.reg_index)
                        REG_CTRL:     result.read_data = state.control;
                        REG_PORT:     result.read_data = state.port;
                        REG_ADDR_LO:  result.read_data = state.a_addr[7:0];
                        REG_ADDR_HI:  result.read_data = state.a_addr[15:8];
                        REG_ADDR_BNK: result.read_data = state.a_addr[23:16];
                        REG_CNT_LO:   result.read_data = state.count[7:0];
                        default:      result.read_data = state.count[15:8];
                    endcase
                end
                else
                begin
                    case (item.reg_index)
                        REG_CTRL:     state_next.control        = item.write_data;
                        REG_PORT:     state_next.port           = item.write_data;
                        REG_ADDR_LO:  state_next.a_addr[7:0]    = item.write_data;
                        REG_ADDR_HI:  state_next.a_addr[15:8]   = item.write_data;
                        REG_ADDR_BNK: state_next.a_addr[23:16]  = item.write_data;
                        REG_CNT_LO:   state_next.count[7:0]     = item.write_data;
                        default:      state_next.count[15:8]    = item.write_data;
                    endcase
                end
            end
            OP_START:
            begin
                state_next.active = 1'b1;
                state_next.phase  = 2'd0;
                state_next.first  = 1'b1;
            end
            OP_STOP:
            begin
                state_next.active = 1'b0;
            end
            OP_STEP:
            begin
                if (state.active)
                begin
                    result.bus_valid     = 1'b1;
                    result.a_bus_address = state.a_addr;
                    result.b_bus_address = B_BASE | {6'd0, b_low};
                    result.b_to_a        = b2a;
                    result.transfer_kind = !wram_port ? KIND_COPY
                                         : (b2a ? KIND_FILL : KIND_TIME);
                    result.master_cycles = cyc_base + (state.first ? CYC_FIRST_ADD : 5'd0);
                    result.last          = (cnt_dec == 16'd0);

                    if (!state.control[CTRL_FIX_BIT])
                        state_next.a_addr[15:0] = lo_step;
                    state_next.count = cnt_dec;
                    state_next.phase = state.phase + 2'd1;
                    state_next.first = 1'b0;
                    if (cnt_dec == 16'd0)
                        state_next.active = 1'b0;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

>>> rtl/dma_channel_transfer_engine.sv
// ----------------------------------------------------------------------------
// dma_channel_transfer_engine
// One general-purpose DMA channel: register access, start/stop, and one bus
// transfer description per step word on an active channel.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  --------------------------------------
//  in       sink       in_valid / in_stall  operation, reg_index, write_data,
//                                           a_in_work_ram
//  out      source     out_valid/out_stall  read_data, bad_register, bus_valid,
//                                           a_bus_address, b_bus_address, b_to_a,
//                                           transfer_kind, master_cycles, last
//
//  Cycles: two-stage flow, input register then result register. A word
//  accepted into the input register is executed against the channel state
//  and lands in the result register; one word per cycle is sustained while
//  out_stall is low. Every word gives exactly one result word.
//  Reset: channel registers clear, both stages empty, channel idle, first-step flag set.
//  Stalls: out_stall holds the result register; the input register then
//  holds too, and in_stall rises only when both stages are full.
//
module dma_channel_transfer_engine
    import dct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [7:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic        a_in_work_ram,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        bad_register,
    output logic        bus_valid,
    output logic [23:0] a_bus_address,
    output logic [13:0] b_bus_address,
    output logic        b_to_a,
    output logic [1:0]  transfer_kind,
    output logic [4:0]  master_cycles,
    output logic        last
);

    // input stage
    logic        in_full_reg;
    logic        in_full_next;
    item_t       item_reg;

    // result stage
    logic        out_full_reg;
    logic        out_full_next;
    result_t     result_reg;

    logic        in_take;
    logic        advance;
    result_t     result_next;
    chan_state_t state;
    chan_state_t state_next;

    // the held word executes when the result register is free or draining
    assign advance  = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign in_full_next  = in_take || (in_full_reg && !advance);
    assign out_full_next = advance || (out_full_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.operation     <= operation;
            item_reg.reg_index     <= reg_index;
            item_reg.write_data    <= write_data;
            item_reg.a_in_work_ram <= a_in_work_ram;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    dct_exec u_exec
    (
        .item       (item_reg),
        .state      (state),
        .result     (result_next),
        .state_next (state_next)
    );

    // channel state moves exactly once per executed word
    dct_chan_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance),
        .state_next (state_next),
        .state      (state)
    );

    assign out_valid     = out_full_reg;
    assign read_data     = result_reg.read_data;
    assign bad_register  = result_reg.bad_register;
    assign bus_valid     = result_reg.bus_valid;
    assign a_bus_address = result_reg.a_bus_address;
    assign b_bus_address = result_reg.b_bus_address;
    assign b_to_a        = result_reg.b_to_a;
    assign transfer_kind = result_reg.transfer_kind;
    assign master_cycles = result_reg.master_cycles;
    assign last          = result_reg.last;

    // ---------------------------------------------------------------- checks

    // a run-ending step leaves the channel idle
    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.last |=> !state.active)
        else $error("channel still active after last step");

    // last only on a real transfer
    a_last_bus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> bus_valid)
        else $error("last without bus transfer");

    // bad offset never comes with a transfer or read data
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_register |-> !bus_valid && read_data == 8'd0)
        else $error("bad register result carries data");

    // fill writes only go B to A and cost CYC_FILL, plus CYC_FIRST_ADD on a first step
    a_fill_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && transfer_kind == KIND_FILL |->
            b_to_a && (master_cycles == CYC_FILL ||
                       master_cycles == CYC_FILL + CYC_FIRST_ADD))
        else $error("malformed fill transfer");

endmodule

>>> tb/sv/dma_channel_transfer_engine_tb.sv
// ----------------------------------------------------------------------------
// dma_channel_transfer_engine_tb
// Self-checking bench for the DMA channel: a scoreboard predictor tracks the
// channel registers and run state, every accepted word is predicted, and every
// result word is compared field by field in order. Stimulus is a directed
// opener followed by random program/start/step sequences mixed with noise.
// ----------------------------------------------------------------------------
module dma_channel_transfer_engine_tb
    import dct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_WORDS = 800;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         MAX_REPORTS  = 60;
    localparam logic [2:0] MODE_QUAD    = 3'd4;   // offset cycles 0..3

    // one queued input word; hold makes the sender wait for a fully drained
    // result path before presenting it
    typedef struct {
        item_t word;
        bit    hold;
    } feed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  operation = OP_READ;
    logic [7:0]  reg_index = '0;
    logic [7:0]  write_data = '0;
    logic        a_in_work_ram = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_data;
    logic        bad_register;
    logic        bus_valid;
    logic [23:0] a_bus_address;
    logic [13:0] b_bus_address;
    logic        b_to_a;
    logic [1:0]  transfer_kind;
    logic [4:0]  master_cycles;
    logic        last;

    dma_channel_transfer_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .reg_index     (reg_index),
        .write_data    (write_data),
        .a_in_work_ram (a_in_work_ram),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .bad_register  (bad_register),
        .bus_valid     (bus_valid),
        .a_bus_address (a_bus_address),
        .b_bus_address (b_bus_address),
        .b_to_a        (b_to_a),
        .transfer_kind (transfer_kind),
        .master_cycles (master_cycles),
        .last          (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Channel shadow state, as it stands after every word accepted so far
    // ------------------------------------------------------------------------
    logic [7:0]  chan_ctrl  = '0;
    logic [7:0]  chan_port  = '0;
    logic [23:0] chan_addr  = '0;
    logic [15:0] chan_count = '0;
    logic        chan_armed = 1'b0;
    logic [1:0]  chan_phase = '0;
    logic        chan_first = 1'b1;

    feed_t   feed[$];               // words waiting to be sent
    result_t pending_results[$];    // predicted results, oldest first
    int      failures = 0;
    int      words_queued = 0;
    int      cycle_count = 0;
    int      burst_left = 1;
    int      gap_left = 0;
    int      stall_span = 0;
    int      stall_style = 0;

    // Applies one word to the shadow state and returns the result word the
    // channel must produce for it.
    function automatic result_t execute_word(input item_t w);
        result_t    r;
        logic [1:0] off;
        logic [7:0] b_low;
        logic       dir;
        r = '0;
        case (w.operation)
            OP_READ, OP_WRITE:
            begin
                if (w.reg_index > REG_CNT_HI)
                begin
                    r.bad_register = 1'b1;
                end
                else if (w.operation == OP_READ)
                begin
                    case (w.reg_index)
                        REG_CTRL:     r.read_data = chan_ctrl;
                        REG_PORT:     r.read_data = chan_port;
                        REG_ADDR_LO:  r.read_data = chan_addr[7:0];
                        REG_ADDR_HI:  r.read_data = chan_addr[15:8];
                        REG_ADDR_BNK: r.read_data = chan_addr[23:16];
                        REG_CNT_LO:   r.read_data = chan_count[7:0];
                        default:      r.read_data = chan_count[15:8];
                    endcase
                end
                else
                begin
                    case (w.reg_index)
                        REG_CTRL:     chan_ctrl = w.write_data;
                        REG_PORT:     chan_port = w.write_data;
                        REG_ADDR_LO:  chan_addr[7:0] = w.write_data;
                        REG_ADDR_HI:  chan_addr[15:8] = w.write_data;
                        REG_ADDR_BNK: chan_addr[23:16] = w.write_data;
                        REG_CNT_LO:   chan_count[7:0] = w.write_data;
                        default:      chan_count[15:8] = w.write_data;
                    endcase
                end
            end
            OP_START:
            begin
                chan_armed = 1'b1;
                chan_phase = '0;
                chan_first = 1'b1;
            end
            OP_STOP:
            begin
                chan_armed = 1'b0;
            end
            OP_STEP:
            begin
                if (chan_armed)
                begin
                    dir = chan_ctrl[CTRL_DIR_BIT];
                    // odd modes alternate (bit 1 picks pairs), mode 4 counts 0..3
                    if (chan_ctrl[2:0] == MODE_QUAD)
                        off = chan_phase;
                    else if (chan_ctrl[0])
                        off = chan_ctrl[1] ? {1'b0, chan_phase > 2'd1} : {1'b0, chan_phase[0]};
                    else
                        off = '0;
                    b_low = chan_port + {6'd0, off};

                    r.bus_valid     = 1'b1;
                    r.a_bus_address = chan_addr;
                    r.b_bus_address = B_BASE | {6'd0, b_low};
                    r.b_to_a        = dir;
                    r.transfer_kind = KIND_COPY;
                    r.master_cycles = CYC_BYTE;
                    if (chan_port == WRAM_PORT && w.a_in_work_ram)
                    begin
                        r.transfer_kind = dir ? KIND_FILL : KIND_TIME;
                        r.master_cycles = dir ? CYC_FILL : CYC_BYTE;
                    end
                    if (chan_first)
                        r.master_cycles = r.master_cycles + CYC_FIRST_ADD;

                    // only the low 16 bits move; bank stays put
                    if (!chan_ctrl[CTRL_FIX_BIT])
                        chan_addr[15:0] = chan_ctrl[CTRL_DEC_BIT] ? chan_addr[15:0] - 16'd1
                                                                  : chan_addr[15:0] + 16'd1;
                    chan_count = chan_count - 16'd1;
                    chan_phase = chan_phase + 2'd1;
                    chan_first = 1'b0;
                    if (chan_count == '0)
                    begin
                        chan_armed = 1'b0;
                        r.last     = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int field_mismatch(input string name, input logic [23:0] want,
                                          input logic [23:0] got);
        if (want === got)
            return 0;
        if (failures < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
        return 1;
    endfunction

    task automatic compare_result(input result_t want, input result_t got);
        int bad;
        bad = 0;
        bad += field_mismatch("read_data",     24'(want.read_data),     24'(got.read_data));
        bad += field_mismatch("bad_register",  24'(want.bad_register),  24'(got.bad_register));
        bad += field_mismatch("bus_valid",     24'(want.bus_valid),     24'(got.bus_valid));
        bad += field_mismatch("a_bus_address", want.a_bus_address,      got.a_bus_address);
        bad += field_mismatch("b_bus_address", 24'(want.b_bus_address), 24'(got.b_bus_address));
        bad += field_mismatch("b_to_a",        24'(want.b_to_a),        24'(got.b_to_a));
        bad += field_mismatch("transfer_kind", 24'(want.transfer_kind), 24'(got.transfer_kind));
        bad += field_mismatch("master_cycles", 24'(want.master_cycles), 24'(got.master_cycles));
        bad += field_mismatch("last",          24'(want.last),          24'(got.last));
        failures += bad;
    endtask

    task automatic queue_word(input logic [2:0] op, input logic [7:0] idx,
                              input logic [7:0] data, input logic wram, input bit hold);
        feed_t f;
        f.word.operation     = op;
        f.word.reg_index     = idx;
        f.word.write_data    = data;
        f.word.a_in_work_ram = wram;
        f.hold               = hold;
        feed.push_back(f);
        words_queued++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued words in bursts with random gaps. The word on
    // the bus is predicted at the edge that accepts it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_words
        item_t on_bus;
        feed_t nxt;
        if (rst_n)
        begin
            on_bus.operation     = operation;
            on_bus.reg_index     = reg_index;
            on_bus.write_data    = write_data;
            on_bus.a_in_work_ram = a_in_work_ram;
            if (in_valid && !in_stall)
                pending_results.push_back(execute_word(on_bus));

            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (feed.size() != 0 && !(feed[0].hold && pending_results.size() != 0))
                begin
                    nxt = feed.pop_front();
                    operation     <= nxt.word.operation;
                    reg_index     <= nxt.word.reg_index;
                    write_data    <= nxt.word.write_data;
                    a_in_work_ram <= nxt.word.a_in_work_ram;
                    in_valid      <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // about a third of bursts run straight into the next
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result word against the oldest
    // prediction, and runs the receiver's stall pattern. The pattern changes
    // style after each random stall span: none, light, heavy, or toggling.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_results
        result_t seen;
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen.read_data     = read_data;
                seen.bad_register  = bad_register;
                seen.bus_valid     = bus_valid;
                seen.a_bus_address = a_bus_address;
                seen.b_bus_address = b_bus_address;
                seen.b_to_a        = b_to_a;
                seen.transfer_kind = transfer_kind;
                seen.master_cycles = master_cycles;
                seen.last          = last;
                if (pending_results.size() == 0)
                begin
                    if (failures < MAX_REPORTS)
                        $display("%0t: result word with nothing expected, expected none actual %0h",
                                 $realtime, seen);
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_result(want, seen);
                end
            end

            if (stall_span == 0)
            begin
                stall_span  = $urandom_range(10, 60);
                stall_style = $urandom_range(0, 3);
            end
            stall_span--;
            case (stall_style)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int         steps;
        int         pick;
        bit         hold;
        logic [7:0] ri;
        logic [7:0] data;

        // directed opener
        queue_word(OP_READ,  REG_CTRL,   8'h00, 1'b0, 1'b0);  // reset value
        queue_word(OP_READ,  8'd7,       8'h00, 1'b0, 1'b0);  // first bad offset
        queue_word(OP_WRITE, 8'hFF,      8'hFF, 1'b1, 1'b0);  // bad write, no effect
        queue_word(OP_STEP,  8'h00,      8'h00, 1'b1, 1'b0);  // step while idle
        queue_word(3'd5,     8'hFF,      8'hFF, 1'b1, 1'b0);  // unknown operations
        queue_word(3'd7,     8'hFF,      8'hFF, 1'b1, 1'b0);
        queue_word(OP_WRITE, REG_CTRL,     8'h84, 1'b0, 1'b0);  // B to A, mode 4
        queue_word(OP_WRITE, REG_PORT,     8'hFE, 1'b0, 1'b0);  // B address wraps
        queue_word(OP_WRITE, REG_ADDR_LO,  8'hFF, 1'b0, 1'b0);
        queue_word(OP_WRITE, REG_ADDR_HI,  8'hFF, 1'b0, 1'b0);  // A low half wraps
        queue_word(OP_WRITE, REG_ADDR_BNK, 8'h7E, 1'b0, 1'b0);
        queue_word(OP_WRITE, REG_CNT_LO,   8'h03, 1'b0, 1'b0);
        queue_word(OP_WRITE, REG_CNT_HI,   8'h00, 1'b0, 1'b0);
        queue_word(OP_START, 8'h00, 8'h00, 1'b0, 1'b0);
        queue_word(OP_STEP,  8'h00, 8'h00, 1'b1, 1'b0);
        queue_word(OP_STEP,  8'h00, 8'h00, 1'b0, 1'b0);
        queue_word(OP_START, 8'h00, 8'h00, 1'b0, 1'b1);         // restart mid-run, after drain
        queue_word(OP_STEP,  8'h00, 8'h00, 1'b0, 1'b0);         // count hits zero: last
        queue_word(OP_STOP,  8'h00, 8'h00, 1'b0, 1'b0);
        queue_word(OP_WRITE, REG_PORT, WRAM_PORT, 1'b0, 1'b0);
        queue_word(OP_WRITE, REG_CTRL, 8'h13, 1'b0, 1'b0);      // decrement, mode 3
        queue_word(OP_WRITE, REG_CNT_LO, 8'h00, 1'b0, 1'b0);    // zero count: full-length run
        queue_word(OP_START, 8'h00, 8'h00, 1'b0, 1'b0);
        queue_word(OP_STEP,  8'h00, 8'h00, 1'b1, 1'b0);         // work RAM, time only
        queue_word(OP_WRITE, REG_CTRL, 8'h88, 1'b0, 1'b0);      // B to A, fixed
        queue_word(OP_STEP,  8'h00, 8'h00, 1'b1, 1'b0);         // work RAM fill
        queue_word(OP_READ,  REG_CNT_HI, 8'h00, 1'b0, 1'b0);
        queue_word(OP_STOP,  8'h00, 8'h00, 1'b0, 1'b0);
        queue_word(OP_STEP,  8'h00, 8'h00, 1'b0, 1'b0);         // stopped: nothing moves

        // random part: mostly program/start/step runs, some noise
        while (words_queued < RANDOM_WORDS + 30)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                queue_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
            end
            else
            begin
                hold = ($urandom_range(0, 24) == 0);
                for (ri = REG_CTRL; ri <= REG_CNT_HI; ri++)
                begin
                    if (ri == REG_CNT_LO || ri == REG_CNT_HI || $urandom_range(0, 9) < 7)
                    begin
                        case (ri)
                            REG_PORT:
                            begin
                                pick = $urandom_range(0, 9);
                                data = (pick < 4) ? WRAM_PORT
                                     : (pick < 6) ? 8'(8'hFF - $urandom_range(0, 2))
                                     : 8'($urandom_range(0, 255));
                            end
                            REG_ADDR_LO, REG_ADDR_HI:
                                data = ($urandom_range(0, 3) == 0) ? 8'hFF
                                                                   : 8'($urandom_range(0, 255));
                            REG_CNT_LO:
                                data = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                                   : 8'($urandom_range(0, 6));
                            REG_CNT_HI:
                                data = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                                   : 8'h00;
                            default:
                                data = 8'($urandom_range(0, 255));
                        endcase
                        queue_word(OP_WRITE, ri, data, 1'($urandom_range(0, 1)), hold);
                        hold = 1'b0;
                    end
                end
                queue_word(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'b0);
                steps = $urandom_range(1, 12);
                repeat (steps)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 6)
                        queue_word(OP_READ, 8'($urandom_range(0, 6)),
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
                    else if (pick < 9)
                        queue_word(OP_WRITE, 8'($urandom_range(0, 6)),
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
                    else if (pick < 11)
                        queue_word(OP_STOP, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
                    else if (pick < 13)
                        queue_word(OP_START, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
                    else
                        queue_word(OP_STEP, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
                end
                if ($urandom_range(0, 3) == 0)
                    queue_word(OP_READ, 8'($urandom_range(0, 6)), 8'h00, 1'b0, 1'b0);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (feed.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        // two-stage pipe: the drain wait catches any stray result word
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
